[rtl/complex_arith_unit_macros.svh]
// Assertion macros shared by the complex arithmetic unit.
// Included by the top level only.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
// implication checked on every clock, masked during reset
`define CAU_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication
`define CAU_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: operation codes and fixed widths.
// No dependencies.
package cau_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4
  } cau_op_t;
  localparam int MODE_W = 3;
endpackage

[rtl/cau_mul.sv]
// Pipelined complex cross products for multiply and divide modes.
// Two register stages; uses cau_pkg.
module cau_mul import cau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [WORD_BITS-1:0]   a_re,
  input  logic signed [WORD_BITS-1:0]   a_im,
  input  logic signed [WORD_BITS-1:0]   b_re,
  input  logic signed [WORD_BITS-1:0]   b_im,
  output logic signed [2*WORD_BITS+1:0] p_rr_m_ii,  // ar*br - ai*bi
  output logic signed [2*WORD_BITS+1:0] p_ri_p_ir,  // ar*bi + ai*br
  output logic signed [2*WORD_BITS+1:0] p_rr_p_ii,  // ar*br + ai*bi
  output logic signed [2*WORD_BITS+1:0] p_ir_m_ri,  // ai*br - ar*bi
  output logic signed [2*WORD_BITS+1:0] p_den       // br^2 + bi^2
);
  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 2;
  logic signed [PW-1:0] rr_r, ii_r, ri_r, ir_r, bb_r, cc_r;
  logic signed [SW-1:0] s0_r, s1_r, s2_r, s3_r, s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r <= a_re * b_re;
      ii_r <= a_im * b_im;
      ri_r <= a_re * b_im;
      ir_r <= a_im * b_re;
      bb_r <= b_re * b_re;
      cc_r <= b_im * b_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= SW'(rr_r) - SW'(ii_r);
      s1_r <= SW'(ri_r) + SW'(ir_r);
      s2_r <= SW'(rr_r) + SW'(ii_r);
      s3_r <= SW'(ir_r) - SW'(ri_r);
      s4_r <= SW'(bb_r) + SW'(cc_r);
    end
  end

  assign p_rr_m_ii = s0_r;
  assign p_ri_p_ir = s1_r;
  assign p_rr_p_ii = s2_r;
  assign p_ir_m_ri = s3_r;
  assign p_den     = s4_r;
endmodule

[rtl/cau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, signed numerator.
// Uses cau_pkg; quotient truncated toward zero.
module cau_div import cau_pkg::*; #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 65
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic signed [NUM_W-1:0] quo
);
  // magnitude fits in NUM_W bits (num never equals the most negative value)
  logic [NUM_W-1:0] mag_r [NUM_W+1];
  logic [NUM_W-1:0] q_r   [NUM_W+1];
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [DEN_W-1:0] d_r   [NUM_W+1];
  logic             neg_r [NUM_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_r[0] <= num[NUM_W-1];
      d_r[0]   <= den;
      q_r[0]   <= '0;
      rem_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] df;
    assign sh = {rem_r[k], mag_r[k][NUM_W-1-k]};
    assign df = sh - (DEN_W+2)'(d_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k+1] <= mag_r[k];
        neg_r[k+1] <= neg_r[k];
        d_r[k+1]   <= d_r[k];
        if (!df[DEN_W+1]) begin
          rem_r[k+1] <= df[DEN_W:0];
          q_r[k+1]   <= q_r[k] | (NUM_W'(1) << (NUM_W-1-k));
        end else begin
          rem_r[k+1] <= sh[DEN_W:0];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  assign quo = neg_r[NUM_W] ? -q_r[NUM_W] : q_r[NUM_W];
endmodule

[rtl/complex_arith_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, divide, negate on Q16.16.
// Uses cau_pkg, cau_mul, cau_div and the assertion macro header.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata and results leave on
//   out_tvalid/out_tready/out_tdata. One result word per input word, in order.
//   The datapath is a fixed pipeline: 2 multiply/sum stages, one operand stage
//   of the divider, one stage per quotient bit (2*WORD_BITS+FRAC_BITS+2 bits),
//   and one saturation/output stage. Every mode passes through the same stages,
//   so all modes share the same delay.
//   Throughput is one word per cycle while the receiver accepts results.
//   When the receiver stalls with a result waiting, the whole pipeline holds;
//   in_tready follows out_tready or an empty output register, so no word is
//   lost or repeated. Reset clears all valid bits; data registers are not reset.
`include "complex_arith_unit_macros.svh"
module complex_arith_unit import cau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // mode[2:0], a_re, a_im, b_re, b_im, zero fill to bytes
  input  logic [((MODE_W+4*WORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // res_re, res_im, div_zero, overflow, zero fill to bytes
  output logic [((2*WORD_BITS+2+7)/8)*8-1:0] out_tdata
);
  localparam int W    = WORD_BITS;
  localparam int SW   = 2 * W + 2;
  localparam int NW   = SW + FRAC_BITS;
  localparam int LAT  = NW + 3;   // stages before output register
  localparam int OW   = ((2*W+2+7)/8)*8;

  logic en;
  logic [MODE_W-1:0] mode;
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  assign mode = in_tdata[MODE_W-1:0];
  assign a_re = in_tdata[MODE_W +: W];
  assign a_im = in_tdata[MODE_W+W +: W];
  assign b_re = in_tdata[MODE_W+2*W +: W];
  assign b_im = in_tdata[MODE_W+3*W +: W];

  // side pipeline: mode, simple results, valid bit
  logic [MODE_W-1:0]   md_r  [LAT];
  logic signed [W+1:0] sr_r  [LAT];
  logic signed [W+1:0] si_r  [LAT];
  // product and zero-divisor stages start where the multiplier output lands
  logic signed [SW-FRAC_BITS-1:0] mr_r [2:LAT-1];
  logic signed [SW-FRAC_BITS-1:0] mi_r [2:LAT-1];
  logic                dz_r  [2:LAT-1];
  logic [LAT-1:0]      vld_r;
  logic                ovalid_r;
  logic [OW-1:0]       odata_r;

  assign en        = out_tready || !ovalid_r;
  assign in_tready = en;

  logic signed [W+1:0] simp_re, simp_im;
  always_comb begin
    case (mode)
      OP_ADD:  begin simp_re = (W+2)'(a_re) + (W+2)'(b_re);
                     simp_im = (W+2)'(a_im) + (W+2)'(b_im); end
      OP_SUB:  begin simp_re = (W+2)'(a_re) - (W+2)'(b_re);
                     simp_im = (W+2)'(a_im) - (W+2)'(b_im); end
      OP_NEG:  begin simp_re = -(W+2)'(a_re);
                     simp_im = -(W+2)'(a_im); end
      default: begin simp_re = '0; simp_im = '0; end
    endcase
  end

  logic signed [SW-1:0] p0, p1, p2, p3, pd;
  cau_mul #(.WORD_BITS(W)) u_mul (
    .clk(clk), .en(en), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .p_rr_m_ii(p0), .p_ri_p_ir(p1), .p_rr_p_ii(p2), .p_ir_m_ri(p3), .p_den(pd)
  );

  logic signed [NW-1:0] q_re, q_im;
  logic [SW-2:0] den_u;
  assign den_u = pd[SW-2:0];
  cau_div #(.NUM_W(NW), .DEN_W(SW-1)) u_div_re (
    .clk(clk), .en(en), .num(NW'(p2) <<< FRAC_BITS), .den(den_u), .quo(q_re)
  );
  cau_div #(.NUM_W(NW), .DEN_W(SW-1)) u_div_im (
    .clk(clk), .en(en), .num(NW'(p3) <<< FRAC_BITS), .den(den_u), .quo(q_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= mode;
      sr_r[0] <= simp_re;
      si_r[0] <= simp_im;
      for (int k = 1; k < LAT; k++) begin
        md_r[k] <= md_r[k-1];
        sr_r[k] <= sr_r[k-1];
        si_r[k] <= si_r[k-1];
      end
      // products are ready after two stages
      mr_r[2] <= (SW-FRAC_BITS)'(p0 >>> FRAC_BITS);
      mi_r[2] <= (SW-FRAC_BITS)'(p1 >>> FRAC_BITS);
      dz_r[2] <= (pd == '0);
      for (int k = 3; k < LAT; k++) begin
        mr_r[k] <= mr_r[k-1];
        mi_r[k] <= mi_r[k-1];
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  // saturate a wide value into W bits
  function automatic logic [W:0] sat_fn(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] hi, lo;
    hi = NW'({1'b0, {(W-1){1'b1}}});
    lo = -hi - NW'(1);
    if (v > hi) sat_fn = {1'b1, hi[W-1:0]};
    else if (v < lo) sat_fn = {1'b1, lo[W-1:0]};
    else sat_fn = {1'b0, v[W-1:0]};
  endfunction

  logic [MODE_W-1:0] fm;
  logic signed [NW-1:0] fre, fim;
  logic [W:0] sre, sim;
  logic fdz, fvalid;
  always_comb begin
    fm     = md_r[LAT-1];
    fdz    = 1'b0;
    fvalid = 1'b1;
    case (fm)
      OP_ADD, OP_SUB, OP_NEG: begin
        fre = NW'(sr_r[LAT-1]); fim = NW'(si_r[LAT-1]);
      end
      OP_MUL: begin
        fre = NW'(mr_r[LAT-1]); fim = NW'(mi_r[LAT-1]);
      end
      OP_DIV: begin
        fre = q_re; fim = q_im;
        fdz = dz_r[LAT-1];
        fvalid = !fdz;
      end
      default: begin
        fre = '0; fim = '0; fvalid = 1'b0;
      end
    endcase
    sre = sat_fn(fre);
    sim = sat_fn(fim);
    if (!fvalid) begin
      sre = '0;
      sim = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (en) begin
      ovalid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odata_r <= OW'({sre[W] | sim[W], fdz, sim[W-1:0], sre[W-1:0]});
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  `CAU_ASSERT_IMP(a_stall_ready, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `CAU_ASSERT_NXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `CAU_ASSERT_IMP(a_dz_no_ovf, clk, rst_n, out_tvalid && out_tdata[2*W],
                  !out_tdata[2*W+1])
endmodule
